FILE: hw/rtl/bqc_pkg.sv
// Shared types and constants for the biquad cascade filter unit.
`default_nettype none

package bqc_pkg;

    localparam int MAX_SECTIONS      = 8;
    localparam int WORDS_PER_SECTION = 7;
    localparam int TABLE_WORDS       = WORDS_PER_SECTION * MAX_SECTIONS;
    localparam int DELAY_WORDS       = 2 * MAX_SECTIONS;
    localparam int SEC_W             = $clog2(MAX_SECTIONS);
    localparam int CADDR_W           = $clog2(TABLE_WORDS);
    localparam int DADDR_W           = $clog2(DELAY_WORDS);

    // Coefficient word offsets within one section
    localparam logic [2:0] W_A2    = 3'd0;
    localparam logic [2:0] W_A1    = 3'd1;
    localparam logic [2:0] W_B2    = 3'd2;
    localparam logic [2:0] W_B1    = 3'd3;
    localparam logic [2:0] W_B0    = 3'd4;
    localparam logic [2:0] W_SHIFT = 3'd5;
    localparam logic [2:0] W_GAIN  = 3'd6;

    // Input kinds carried on tuser
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    // Configuration register indexes
    localparam logic CFG_NUM_BIQUADS = 1'b0;
    localparam logic CFG_SECTIONS    = 1'b1;

    // Base of the gain shift minus one (45 - 31 - 1)
    localparam logic [5:0] GAIN_SHIFT_M1 = 6'd13;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_MUL,
        S_POST,
        S_ROUND,
        S_SAT,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_B0,
        OP_B1,
        OP_A1,
        OP_B2,
        OP_A2,
        OP_SH,
        OP_G
    } t_op;

endpackage

`default_nettype wire

FILE: hw/rtl/biquad_cascade_df2t_filter_unit.sv
// Top level: cascade of DF2T biquads on one byte-serial multiply-accumulate unit.
//
//  Channel   Group          Handshake            Contents
//  input     i_s_* / o_s_*  tvalid & tready      sample or coefficient request
//  output    o_m_* / i_m_*  tvalid & tready      filtered sample
//  config    i_cfg_*        write enable only    num_biquads, sections_per_chain
//
// A coefficient request is taken in idle without leaving it. For a sample request, each of
// six products per section walks the multiplier through a byte shift register, with a
// table fetch before it and a post step after it.
// Reset clears the delay line state at once through per-word valid bits; the coefficient
// table is undefined until written. A waiting result does not block the next request;
// a finished sample holds in the sequencer only while the output register is still full.
`default_nettype none

module biquad_cascade_df2t_filter_unit
    import bqc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tdata: sample_in[31:0], coef_index[37:32], coef_value[69:38], zero pad[71:70]
    input  wire logic [71:0] i_s_tdata,
    // tuser: func[0]
    input  wire logic        i_s_tuser,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // tdata: sample_out[31:0]
    output logic [31:0]      o_m_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [3:0]  i_cfg_wdata
);

    t_state r_state, n_state;
    t_op    r_op;

    logic [3:0]         r_nbq, r_spc;
    logic [SEC_W-1:0]   r_sec;
    logic [3:0]         r_pos;
    logic [1:0]         r_k;
    logic [31:0]        r_sample, r_x, r_y, r_total, r_mc, r_mp;
    logic [4:0]         r_sh;
    logic [63:0]        r_acc;
    logic [31:0]        r_cq;
    logic [63:0]        r_dq;
    logic               r_dv;
    logic [31:0]        r_out;
    logic               r_out_valid;

    logic [31:0]        coef_mem [TABLE_WORDS];
    logic [63:0]        dly_mem  [DELAY_WORDS];
    logic [DELAY_WORDS-1:0] r_dly_valid;

    logic               s_acc;
    logic               cfg_ok;
    logic               last_sec, chain_end;
    logic [2:0]         word_sel;
    logic [CADDR_W-1:0] c_raddr;
    logic [DADDR_W-1:0] d_raddr, d_waddr;
    logic               d_we;
    logic [40:0]        pp;
    logic [63:0]        pp_ext;
    logic [63:0]        y_round;
    logic [63:0]        g_inc, g_half;
    logic [31:0]        x_sat;
    logic [32:0]        tot_sum;
    logic [31:0]        tot_sat;
    logic               out_free;

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign cfg_ok   = (r_nbq != 4'd0) && (r_nbq <= 4'(MAX_SECTIONS)) && (r_spc != 4'd0);
    assign last_sec = (4'(r_sec) + 4'd1) == r_nbq;
    assign chain_end = ((r_pos + 4'd1) == r_spc) || last_sec;
    assign out_free = !r_out_valid || i_m_tready;

    // Word offset of the current step
    always_comb begin
        case (r_op)
            OP_B0:   word_sel = W_B0;
            OP_B1:   word_sel = W_B1;
            OP_A1:   word_sel = W_A1;
            OP_B2:   word_sel = W_B2;
            OP_A2:   word_sel = W_A2;
            OP_SH:   word_sel = W_SHIFT;
            OP_G:    word_sel = W_GAIN;
            default: word_sel = W_GAIN;
        endcase
    end

    // Byte digit times coefficient; only the top digit is signed
    assign pp     = 41'($signed(r_mc) * $signed({(r_k == 2'd3) & r_mp[7], r_mp[7:0]}));
    assign pp_ext = {{23{pp[40]}}, pp} << {r_k, 3'b000};

    assign y_round = r_acc + 64'h0000_0000_2000_0000;
    assign g_inc   = r_acc + 64'd1;
    assign g_half  = {g_inc[63], g_inc[63:1]};

    always_comb begin
        if (&g_half[63:31] || ~|g_half[63:31]) begin
            x_sat = g_half[31:0];
        end else if (g_half[63]) begin
            x_sat = 32'h8000_0000;
        end else begin
            x_sat = 32'h7FFF_FFFF;
        end
    end

    assign tot_sum = {r_total[31], r_total} + {x_sat[31], x_sat};
    always_comb begin
        case (tot_sum[32:31])
            2'b01:   tot_sat = 32'h7FFF_FFFF;
            2'b10:   tot_sat = 32'h8000_0000;
            default: tot_sat = tot_sum[31:0];
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc && i_s_tuser == FUNC_SAMPLE) begin
                    n_state = cfg_ok ? S_FETCH : S_DONE;
                end
            end
            S_FETCH: n_state = S_LOAD;
            S_LOAD:  n_state = (r_op == OP_SH) ? S_FETCH : S_MUL;
            S_MUL:   n_state = (r_k == 2'd3) ? S_POST : S_MUL;
            S_POST:  n_state = (r_op == OP_G) ? S_ROUND : S_FETCH;
            S_ROUND: n_state = S_SAT;
            S_SAT:   n_state = last_sec ? S_DONE : S_FETCH;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and memory controls
    always_comb begin
        o_s_tready = 1'b0;
        d_we       = 1'b0;
        c_raddr    = CADDR_W'({r_sec, 3'b000}) - CADDR_W'(r_sec) + CADDR_W'(word_sel);
        d_raddr    = {r_sec, (r_op != OP_B0)};
        d_waddr    = {r_sec, (r_op == OP_A2)};
        case (r_state)
            S_IDLE:  o_s_tready = 1'b1;
            S_POST:  d_we = (r_op == OP_A1) || (r_op == OP_A2);
            default: d_we = 1'b0;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    // Memories
    always_ff @(posedge i_clk) begin
        if (s_acc && i_s_tuser == FUNC_COEF && i_s_tdata[37:32] < 6'(TABLE_WORDS)) begin
            coef_mem[i_s_tdata[32 +: CADDR_W]] <= i_s_tdata[69:38];
        end
        if (d_we) begin
            dly_mem[d_waddr] <= r_acc;
        end
        r_cq <= coef_mem[c_raddr];
        r_dq <= dly_mem[d_raddr];
        r_dv <= r_dly_valid[d_raddr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nbq       <= 4'd1;
            r_spc       <= 4'd1;
            r_dly_valid <= '0;
            r_out_valid <= 1'b0;
            r_k         <= 2'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_NUM_BIQUADS) begin
                    r_nbq <= i_cfg_wdata;
                end else if (i_cfg_addr == CFG_SECTIONS) begin
                    r_spc <= i_cfg_wdata;
                end
            end
            if (d_we) begin
                r_dly_valid[d_waddr] <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_k <= (r_state == S_MUL) ? r_k + 2'd1 : 2'd0;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sample <= i_s_tdata[31:0];
                r_x      <= i_s_tdata[31:0];
                r_total  <= 32'd0;
                r_sec    <= '0;
                r_pos    <= 4'd0;
                r_op     <= OP_B0;
            end
            S_LOAD: begin
                r_mc <= r_cq;
                case (r_op)
                    OP_B0, OP_B1: begin
                        r_acc <= r_dv ? r_dq : 64'd0;
                        r_mp  <= r_x;
                    end
                    OP_A1, OP_A2: r_mp <= r_y;
                    OP_B2: begin
                        r_acc <= 64'd0;
                        r_mp  <= r_x;
                    end
                    OP_SH: begin
                        r_sh <= r_cq[4:0];
                        r_op <= OP_G;
                    end
                    default: begin
                        r_acc <= 64'd0;
                        r_mp  <= r_y;
                    end
                endcase
            end
            S_MUL: begin
                r_acc <= r_acc + pp_ext;
                r_mp  <= {8'd0, r_mp[31:8]};
            end
            S_POST: begin
                case (r_op)
                    OP_B0: begin
                        r_y  <= y_round[61:30];
                        r_op <= OP_B1;
                    end
                    OP_B1:   r_op <= OP_A1;
                    OP_A1:   r_op <= OP_B2;
                    OP_B2:   r_op <= OP_A2;
                    OP_A2:   r_op <= OP_SH;
                    default: r_op <= OP_G;
                endcase
            end
            S_ROUND: begin
                r_acc <= $signed(r_acc) >>> (GAIN_SHIFT_M1 + 6'(r_sh));
            end
            S_SAT: begin
                r_op  <= OP_B0;
                r_sec <= r_sec + SEC_W'(1);
                if (chain_end) begin
                    r_total <= tot_sat;
                    r_x     <= r_sample;
                    r_pos   <= 4'd0;
                end else begin
                    r_x   <= x_sat;
                    r_pos <= r_pos + 4'd1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out <= r_total;
                end
            end
            default: r_op <= r_op;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> r_state == S_IDLE)
        else $error("input ready outside idle");

    a_mul_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_MUL |=> r_k == 2'd0 || r_state == S_MUL)
        else $error("multiply digit counter out of step");

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |-> 4'(r_sec) < r_nbq)
        else $error("section index beyond section count");

    a_mul_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_MUL) |-> $past(r_state) == S_LOAD)
        else $error("multiply entered without operand load");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the biquad cascade filter unit with an in-line cascade predictor.
`default_nettype none

module tb
    import bqc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    class cascade_tracker;
        logic [31:0] coefs [TABLE_WORDS];
        logic [63:0] delays [DELAY_WORDS];
        logic [3:0]  n_sections;
        logic [3:0]  chain_len;
        logic [31:0] pending_out [$];
        int          mismatches;
        int          unexpected;

        function new();
            n_sections = 4'd1;
            chain_len  = 4'd1;
            mismatches = 0;
            unexpected = 0;
            foreach (delays[k]) delays[k] = '0;
            foreach (coefs[k]) coefs[k] = '0;
        endfunction

        function void set_reg(logic addr, logic [3:0] val);
            if (addr == CFG_NUM_BIQUADS) n_sections = val;
            else chain_len = val;
        endfunction

        static function logic [63:0] sext(logic [31:0] v);
            return {{32{v[31]}}, v};
        endfunction

        // arithmetic shift by s-1, add one, shift once more
        static function logic [63:0] round_sh(logic [63:0] v, int s);
            logic [63:0] t;
            t = $signed(v) >>> (s - 1);
            t = t + 64'd1;
            return $signed(t) >>> 1;
        endfunction

        static function logic [63:0] sat32(logic [63:0] v);
            if ($signed(v) < -64'sd2147483648) return 64'hFFFF_FFFF_8000_0000;
            if ($signed(v) > 64'sd2147483647) return 64'h0000_0000_7FFF_FFFF;
            return v;
        endfunction

        function logic [63:0] cw(int sec, logic [2:0] w);
            return sext(coefs[sec * WORDS_PER_SECTION + w]);
        endfunction

        function void note_request(logic func, logic [31:0] smp, logic [5:0] idx,
                                   logic [31:0] val);
            logic [63:0] total, x, acc, y, d0, d1;
            int n, per, sec, s;
            if (func == FUNC_COEF) begin
                if (idx < TABLE_WORDS) coefs[idx] = val;
                return;
            end
            total = '0;
            n = int'(n_sections);
            per = int'(chain_len);
            if (n >= 1 && n <= MAX_SECTIONS && per >= 1) begin
                for (int j = 0; j < n; j += per) begin
                    x = sext(smp);
                    for (int i = 0; i < per && j + i < n; i++) begin
                        sec = j + i;
                        d0 = delays[2 * sec];
                        d1 = delays[2 * sec + 1];
                        acc = cw(sec, W_B0) * x + d0;
                        acc = round_sh(acc, 30);
                        y = sext(acc[31:0]);
                        delays[2 * sec]     = d1 + cw(sec, W_B1) * x + cw(sec, W_A1) * y;
                        delays[2 * sec + 1] = cw(sec, W_B2) * x + cw(sec, W_A2) * y;
                        s = int'(coefs[sec * WORDS_PER_SECTION + W_SHIFT][4:0]);
                        acc = cw(sec, W_GAIN) * y;
                        x = sat32(round_sh(acc, 14 + s));
                    end
                    total = sat32(total + x);
                end
            end
            pending_out.push_back(total[31:0]);
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (pending_out.size() == 0) begin
                unexpected++;
                if (unexpected + mismatches <= 10)
                    $display("unexpected sample_out %h", got);
                return;
            end
            want = pending_out.pop_front();
            if (got !== want) begin
                mismatches++;
                if (unexpected + mismatches <= 10)
                    $display("sample_out mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic [71:0] i_s_tdata;
    logic        i_s_tuser;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] o_m_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [3:0]  i_cfg_wdata;

    cascade_tracker tracker;
    bit calm;
    bit hold_req;

    biquad_cascade_df2t_filter_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[biquad_cascade_df2t_filter_unit] ERROR");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (2000) @(posedge i_clk);
            end
            i_m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 21);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) tracker.check_result(o_m_tdata);
    end

    task automatic send(logic func, logic [31:0] smp, logic [5:0] idx, logic [31:0] val);
        int gap;
        gap = 0;
        if (!calm) while ($urandom_range(99) < 21) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {2'b00, val, idx, smp};
        @(negedge i_clk);
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
        tracker.note_request(func, smp, idx, val);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (tracker.pending_out.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_chain(logic [3:0] nb, logic [3:0] per);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_NUM_BIQUADS;
        i_cfg_wdata <= nb;
        @(posedge i_clk);
        tracker.set_reg(CFG_NUM_BIQUADS, nb);
        i_cfg_addr  <= CFG_SECTIONS;
        i_cfg_wdata <= per;
        @(posedge i_clk);
        tracker.set_reg(CFG_SECTIONS, per);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coef(logic [2:0] w);
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: begin
                if (w == W_SHIFT) return $urandom_range(3) | ($urandom & 32'hFFFF_FFE0);
                if (w == W_GAIN) return $urandom_range(32767) - 16384;
                return $urandom_range(32'h3FFF_FFFF) - 32'h2000_0000;
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [3:0] nb_list [12];
        logic [3:0] per_list [12];
        logic [5:0] idx;
        nb_list  = '{4'd1, 4'd8, 4'd8, 4'd8, 4'd5, 4'd0, 4'd9, 4'd15,
                     4'd4, 4'd3, 4'd6, 4'd7};
        per_list = '{4'd1, 4'd8, 4'd1, 4'd3, 4'd2, 4'd1, 4'd1, 4'd15,
                     4'd0, 4'd5, 4'd4, 4'd2};
        tracker     = new();
        calm        = 1'b0;
        hold_req    = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tuser   = FUNC_SAMPLE;
        i_s_tdata   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = CFG_NUM_BIQUADS;
        i_cfg_wdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // load the whole table before any section reads it
        for (int k = 0; k < TABLE_WORDS; k++)
            send(FUNC_COEF, $urandom, k[5:0], pick_coef(3'(k % WORDS_PER_SECTION)));

        // directed: sample extremes, ignored writes beyond the table, full-scale gain, high-only shift bits
        send(FUNC_SAMPLE, 32'h7FFF_FFFF, '0, '0);
        send(FUNC_SAMPLE, 32'h8000_0000, '0, '0);
        send(FUNC_SAMPLE, 32'h0000_0000, '0, '0);
        send(FUNC_SAMPLE, 32'hFFFF_FFFF, '0, '0);
        send(FUNC_COEF, '0, 6'd63, 32'hFFFF_FFFF);
        send(FUNC_COEF, '0, 6'd56, 32'h1234_5678);
        send(FUNC_SAMPLE, 32'h0000_0001, 6'h3F, 32'hFFFF_FFFF);
        send(FUNC_COEF, '0, 6'(0 * WORDS_PER_SECTION + W_GAIN), 32'h7FFF_FFFF);
        send(FUNC_COEF, '0, 6'(W_SHIFT), 32'hFFFF_FFE0);
        send(FUNC_SAMPLE, 32'h7FFF_FFFF, '0, '0);
        send(FUNC_SAMPLE, 32'h8000_0000, '0, '0);

        for (int p = 0; p < 12; p++) begin
            set_chain(nb_list[p], per_list[p]);
            for (int k = 0; k < 92; k++) begin
                calm = (p == 3);
                if (p == 6 && k == 10) hold_req = 1'b1;
                if ($urandom_range(99) < 15) begin
                    idx = 6'($urandom_range(63));
                    send(FUNC_COEF, $urandom, idx, pick_coef(3'(idx % WORDS_PER_SECTION)));
                end else begin
                    send(FUNC_SAMPLE, pick_sample(), 6'($urandom), $urandom);
                end
            end
            calm = 1'b0;
        end

        drain();
        if (tracker.mismatches == 0 && tracker.unexpected == 0 &&
            tracker.pending_out.size() == 0)
            $display("[biquad_cascade_df2t_filter_unit] OK");
        else
            $display("[biquad_cascade_df2t_filter_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/bqc_pkg.sv
hw/rtl/biquad_cascade_df2t_filter_unit.sv
verif/tb.sv
